FILE: rtl/assert_macros.svh
// Assertion helpers, included by rtl/rf_pulse_width_frame_decoder.sv, the one RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("same-cycle implication check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle implication check failed");

`endif

FILE: rtl/rfpwd_pkg.sv
`timescale 1ns / 1ps

package rfpwd_pkg;

    localparam int TIME_W     = 16;
    localparam int PERIOD_W   = 8;
    localparam int BYTE_W     = 8;
    localparam int FRAME_W    = 64;
    localparam int COUNT_W    = 6;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_HEAD_HIGH_MIN  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEAD_HIGH_MAX  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEAD_LOW_MIN   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEAD_LOW_MAX   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD_MIN = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD_MAX = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_PART_MIN   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_CODE    = 4'd7;

    typedef struct packed {
        logic [TIME_W-1:0]   head_high_min;
        logic [TIME_W-1:0]   head_high_max;
        logic [TIME_W-1:0]   head_low_min;
        logic [TIME_W-1:0]   head_low_max;
        logic [PERIOD_W-1:0] bit_period_min;
        logic [PERIOD_W-1:0] bit_period_max;
        logic [TIME_W-1:0]   bit_part_min;
        logic [BYTE_W-1:0]   header_code;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        head_high_min:  16'd23,
        head_high_max:  16'd43,
        head_low_min:   16'd3,
        head_low_max:   16'd7,
        bit_period_min: 8'd3,
        bit_period_max: 8'd9,
        bit_part_min:   16'd1,
        header_code:    8'd0
    };

    // Pulse classification handed from the classifier to the frame tracker.
    typedef struct packed {
        logic head_hit;
        logic bit_hit;
        logic bit_value;
    } pulse_class_t;

    typedef struct packed {
        logic               frame_done;
        logic               frame_ok;
        logic [FRAME_W-1:0] frame_data;
    } result_t;

endpackage

FILE: rtl/rf_pulse_width_frame_decoder.sv
// An accepted pulse is classified from the input register and moves to the result register
// once that register is free, and waits there for m_tready. Throughput: one pulse per cycle
// while m_tready is high; the input register and the result register form the pipe.
// The result register frees the input side whenever m_tready is high or it is empty.
// Reset: rst_n clears the pipeline valids and the frame tracker to hunting,
// and loads all configuration registers with their default values.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rf_pulse_width_frame_decoder (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,   // hi_ticks[15:0], lo_ticks[31:16]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [63:0]                       m_tdata,   // frame_data[63:0]
    output logic                              m_tlast,   // frame_done
    output logic                              m_tuser,   // frame_ok
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rfpwd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rfpwd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rfpwd_pkg::*;

    cfg_t               cfg_reg;
    cfg_t               cfg_next;
    logic               in_valid_reg;
    logic               in_valid_next;
    logic [TIME_W-1:0]  in_high_reg;
    logic [TIME_W-1:0]  in_low_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    result_t            out_reg;
    logic               advance;
    pulse_class_t       pulse;
    result_t            result;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_HEAD_HIGH_MIN:  cfg_next.head_high_min  = cfg_data;
                REG_HEAD_HIGH_MAX:  cfg_next.head_high_max  = cfg_data;
                REG_HEAD_LOW_MIN:   cfg_next.head_low_min   = cfg_data;
                REG_HEAD_LOW_MAX:   cfg_next.head_low_max   = cfg_data;
                REG_BIT_PERIOD_MIN: cfg_next.bit_period_min = cfg_data[PERIOD_W-1:0];
                REG_BIT_PERIOD_MAX: cfg_next.bit_period_max = cfg_data[PERIOD_W-1:0];
                REG_BIT_PART_MIN:   cfg_next.bit_part_min   = cfg_data;
                REG_HEADER_CODE:    cfg_next.header_code    = cfg_data[BYTE_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    // A pulse moves out of the input register whenever the result register can take it.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= CFG_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_high_reg <= s_tdata[15:0];
            in_low_reg  <= s_tdata[31:16];
        end
        if (advance)
        begin
            out_reg <= result;
        end
    end

    rfpwd_classify u_classify (
        .hi_ticks (in_high_reg),
        .lo_ticks (in_low_reg),
        .cfg      (cfg_reg),
        .pulse    (pulse)
    );

    rfpwd_frame u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .pulse       (pulse),
        .header_code (cfg_reg.header_code),
        .result      (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.frame_data;
    assign m_tlast  = out_reg.frame_done;
    assign m_tuser  = out_reg.frame_ok;

    `ASSERT_IMPLIES(a_ok_needs_done, clk, rst_n, m_tvalid && m_tuser, m_tlast)
    `ASSERT_IMPLIES(a_data_zero_without_frame, clk, rst_n, m_tvalid && !m_tlast, m_tdata == '0)
    `ASSERT_IMPLIES(a_ready_when_empty, clk, rst_n, !in_valid_reg, s_tready)
    `ASSERT_NEXT(a_advance_fills_output, clk, rst_n, advance, m_tvalid)

endmodule

FILE: rtl/rfpwd_classify.sv
`timescale 1ns / 1ps

module rfpwd_classify (
    input  logic [rfpwd_pkg::TIME_W-1:0] hi_ticks,
    input  logic [rfpwd_pkg::TIME_W-1:0] lo_ticks,
    input  rfpwd_pkg::cfg_t              cfg,
    output rfpwd_pkg::pulse_class_t      pulse
);
    import rfpwd_pkg::*;

    logic [PERIOD_W-1:0] period;

    // Only the low byte of the period is kept, so long pulses wrap around.
    assign period = hi_ticks[PERIOD_W-1:0] + lo_ticks[PERIOD_W-1:0];

    assign pulse.head_hit = (hi_ticks >= cfg.head_high_min) && (hi_ticks <= cfg.head_high_max)
                         && (lo_ticks >= cfg.head_low_min) && (lo_ticks <= cfg.head_low_max);

    assign pulse.bit_hit = (period >= cfg.bit_period_min) && (period <= cfg.bit_period_max)
                        && (hi_ticks >= cfg.bit_part_min) && (lo_ticks >= cfg.bit_part_min);

    assign pulse.bit_value = (hi_ticks > lo_ticks);

endmodule

FILE: rtl/rfpwd_frame.sv
`timescale 1ns / 1ps

module rfpwd_frame (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  rfpwd_pkg::pulse_class_t       pulse,
    input  logic [rfpwd_pkg::BYTE_W-1:0]  header_code,
    output rfpwd_pkg::result_t            result
);
    import rfpwd_pkg::*;

    logic               in_frame_reg;
    logic               in_frame_next;
    logic [COUNT_W-1:0] bit_count_reg;
    logic [COUNT_W-1:0] bit_count_next;
    logic [FRAME_W-1:0] shift_reg;
    logic [FRAME_W-1:0] shift_next;
    logic [BYTE_W-1:0]  sum;
    logic               last_bit;

    assign shift_next = {shift_reg[FRAME_W-2:0], pulse.bit_value};
    assign last_bit   = (bit_count_reg == {COUNT_W{1'b1}});

    // Checksum covers bytes 1 to 6; byte 0 sits in the top eight bits.
    assign sum = shift_next[55:48] + shift_next[47:40] + shift_next[39:32]
               + shift_next[31:24] + shift_next[23:16] + shift_next[15:8];

    always_comb
    begin
        in_frame_next  = in_frame_reg;
        bit_count_next = bit_count_reg;
        result         = '0;
        if (!in_frame_reg)
        begin
            if (pulse.head_hit)
            begin
                in_frame_next  = 1'b1;
                bit_count_next = '0;
            end
        end
        else if (pulse.bit_hit)
        begin
            bit_count_next = bit_count_reg + 1'b1;
            if (last_bit)
            begin
                in_frame_next     = 1'b0;
                result.frame_done = 1'b1;
                result.frame_ok   = (shift_next[63:56] == header_code)
                                 && (shift_next[7:0] == sum);
                result.frame_data = shift_next;
            end
        end
        else
        begin
            in_frame_next  = 1'b0;
            bit_count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg  <= 1'b0;
            bit_count_reg <= '0;
        end
        else if (step)
        begin
            in_frame_reg  <= in_frame_next;
            bit_count_reg <= bit_count_next;
        end
    end

    // Shift contents are fully replaced within every frame, so no reset.
    always_ff @(posedge clk)
    begin
        if (step && in_frame_reg && pulse.bit_hit)
        begin
            shift_reg <= shift_next;
        end
    end

endmodule

FILE: tb/rf_pulse_width_frame_decoder_tb.sv
`timescale 1ns / 1ps

module rf_pulse_width_frame_decoder_tb;

    import rfpwd_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 4;

    // Indexes past the end of the register list; writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LOW  = 4'd8;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HIGH = 4'd15;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [63:0]           m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Local copy of the decoder: its settings and its frame tracker.
    cfg_t               pulse_cfg     = CFG_RESET;
    logic               tracking      = 1'b0;
    logic [COUNT_W-1:0] bits_seen     = '0;
    logic [FRAME_W-1:0] frame_shift   = '0;
    result_t            expected_results[$];

    int          send_idle_pct   = 0;
    int          recv_idle_pct   = 0;
    logic        recv_hold       = 1'b0;
    int          error_count     = 0;
    int          pulses_sent     = 0;
    int          results_checked = 0;
    int          frames_done     = 0;
    int          frames_good     = 0;
    int          reg_writes      = 0;
    int unsigned cycle_count     = 0;

    rf_pulse_width_frame_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("rf_pulse_width_frame_decoder regression: fail");
            $finish;
        end
    end

    function automatic logic [7:0] payload_sum(input logic [FRAME_W-1:0] frame);
        logic [7:0] sum;
        sum = '0;
        for (int k = 1; k <= 6; k++)
        begin
            sum = sum + frame[63 - 8 * k -: 8];
        end
        return sum;
    endfunction

    // Advance the frame tracker by one pulse and queue the result it produces.
    task automatic decode_pulse(input logic [TIME_W-1:0] hi, input logic [TIME_W-1:0] lo);
        logic [PERIOD_W-1:0] period;
        result_t             res;
        period = hi[7:0] + lo[7:0];
        res = '0;
        if (!tracking)
        begin
            if (hi >= pulse_cfg.head_high_min && hi <= pulse_cfg.head_high_max &&
                lo >= pulse_cfg.head_low_min && lo <= pulse_cfg.head_low_max)
            begin
                tracking  = 1'b1;
                bits_seen = '0;
            end
        end
        else if (period >= pulse_cfg.bit_period_min && period <= pulse_cfg.bit_period_max &&
                 hi >= pulse_cfg.bit_part_min && lo >= pulse_cfg.bit_part_min)
        begin
            frame_shift = {frame_shift[62:0], hi > lo};
            bits_seen   = bits_seen + 1'b1;
            if (bits_seen == '0)
            begin
                res.frame_done = 1'b1;
                res.frame_ok   = frame_shift[63:56] == pulse_cfg.header_code &&
                                 frame_shift[7:0] == payload_sum(frame_shift);
                res.frame_data = frame_shift;
                tracking       = 1'b0;
            end
        end
        else
        begin
            tracking  = 1'b0;
            bits_seen = '0;
        end
        expected_results.push_back(res);
    endtask

    task automatic apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_HEAD_HIGH_MIN:  pulse_cfg.head_high_min  = value;
            REG_HEAD_HIGH_MAX:  pulse_cfg.head_high_max  = value;
            REG_HEAD_LOW_MIN:   pulse_cfg.head_low_min   = value;
            REG_HEAD_LOW_MAX:   pulse_cfg.head_low_max   = value;
            REG_BIT_PERIOD_MIN: pulse_cfg.bit_period_min = value[7:0];
            REG_BIT_PERIOD_MAX: pulse_cfg.bit_period_max = value[7:0];
            REG_BIT_PART_MIN:   pulse_cfg.bit_part_min   = value;
            REG_HEADER_CODE:    pulse_cfg.header_code    = value[7:0];
            default: ;
        endcase
    endtask

    task automatic check_result();
        result_t want;
        if (expected_results.size() == 0)
        begin
            $error("unexpected result: frame_done %0b frame_ok %0b frame_data %h",
                   m_tlast, m_tuser, m_tdata);
            error_count++;
            return;
        end
        want = expected_results.pop_front();
        results_checked++;
        if (want.frame_done)
            frames_done++;
        if (want.frame_ok)
            frames_good++;
        if (m_tlast !== want.frame_done)
        begin
            $error("frame_done mismatch: expected %0b, got %0b", want.frame_done, m_tlast);
            error_count++;
        end
        if (m_tuser !== want.frame_ok)
        begin
            $error("frame_ok mismatch: expected %0b, got %0b", want.frame_ok, m_tuser);
            error_count++;
        end
        if (m_tdata !== want.frame_data)
        begin
            $error("frame_data mismatch: expected %h, got %h", want.frame_data, m_tdata);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            check_result();
        m_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic hold_receiver(input int cycles);
        recv_hold <= 1'b1;
        repeat (cycles) @(posedge clk);
        recv_hold <= 1'b0;
    endtask

    task automatic send_pulse(input logic [TIME_W-1:0] hi, input logic [TIME_W-1:0] lo);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {lo, hi};
        do
            @(posedge clk);
        while (!s_tready);
        decode_pulse(hi, lo);
        pulses_sent++;
    endtask

    task automatic wait_until_idle();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Leaves cfg_valid high so back-to-back writes need no gap; the caller lowers it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_reg_write(idx, value);
        reg_writes++;
    endtask

    // The 8-bit registers get random upper data bits, which the block must drop.
    task automatic load_settings(input cfg_t c);
        wait_until_idle();
        write_reg(REG_HEAD_HIGH_MIN, c.head_high_min);
        write_reg(REG_HEAD_HIGH_MAX, c.head_high_max);
        write_reg(REG_HEAD_LOW_MIN, c.head_low_min);
        write_reg(REG_HEAD_LOW_MAX, c.head_low_max);
        write_reg(REG_BIT_PERIOD_MIN, {8'($urandom), c.bit_period_min});
        write_reg(REG_BIT_PERIOD_MAX, {8'($urandom), c.bit_period_max});
        write_reg(REG_BIT_PART_MIN, c.bit_part_min);
        write_reg(REG_HEADER_CODE, {8'($urandom), c.header_code});
        cfg_valid <= 1'b0;
    endtask

    // Pick a pulse that encodes one data bit under the current settings. About a
    // quarter of the candidates use large times whose sum wraps into the window.
    task automatic pick_bit_pulse(input logic bit_value,
                                  output logic [TIME_W-1:0] hi,
                                  output logic [TIME_W-1:0] lo);
        logic [PERIOD_W-1:0] period;
        for (int tries = 0; tries < 200; tries++)
        begin
            period = 8'($urandom_range(int'(pulse_cfg.bit_period_max),
                                       int'(pulse_cfg.bit_period_min)));
            if ($urandom_range(3) == 0)
            begin
                lo       = 16'($urandom);
                hi[15:8] = 8'($urandom);
                hi[7:0]  = period - lo[7:0];
            end
            else
            begin
                lo = 16'($urandom_range(int'(period)));
                hi = 16'(period) - lo;
            end
            if ((hi > lo) == bit_value && hi >= pulse_cfg.bit_part_min &&
                lo >= pulse_cfg.bit_part_min)
                return;
        end
    endtask

    function automatic logic [FRAME_W-1:0] make_frame(input logic well_formed);
        logic [FRAME_W-1:0] frame;
        frame = {$urandom, $urandom};
        case ($urandom_range(19))
            0: frame = '0;
            1: frame = '1;
            default: ;
        endcase
        if (well_formed)
        begin
            frame[63:56] = pulse_cfg.header_code;
            frame[7:0]   = payload_sum(frame);
        end
        return frame;
    endfunction

    // A header pulse, then the frame MSB first; at bit position cut_at a bad
    // pulse goes out instead and the frame is abandoned.
    task automatic send_frame(input logic [FRAME_W-1:0] frame, input int cut_at);
        logic [TIME_W-1:0] hi;
        logic [TIME_W-1:0] lo;
        hi = 16'($urandom_range(int'(pulse_cfg.head_high_max), int'(pulse_cfg.head_high_min)));
        lo = 16'($urandom_range(int'(pulse_cfg.head_low_max), int'(pulse_cfg.head_low_min)));
        send_pulse(hi, lo);
        for (int i = 0; i < FRAME_W; i++)
        begin
            if (i == cut_at)
            begin
                send_pulse(16'(pulse_cfg.bit_period_max) + 16'd1, 16'd0);
                return;
            end
            pick_bit_pulse(frame[63 - i], hi, lo);
            send_pulse(hi, lo);
        end
    endtask

    task automatic send_noise();
        logic [TIME_W-1:0] hi;
        logic [TIME_W-1:0] lo;
        case ($urandom_range(2))
            0:
            begin
                hi = 16'($urandom);
                lo = 16'($urandom);
            end
            1:
            begin
                hi = 16'($urandom_range(63));
                lo = 16'($urandom_range(63));
            end
            default:
            begin
                hi = pulse_cfg.head_high_min + 16'($urandom_range(4)) - 16'd2;
                lo = pulse_cfg.head_low_max + 16'($urandom_range(4)) - 16'd2;
            end
        endcase
        send_pulse(hi, lo);
    endtask

    task automatic run_traffic(input int frames);
        for (int f = 0; f < frames; f++)
        begin
            repeat ($urandom_range(3)) send_noise();
            send_frame(make_frame($urandom_range(3) != 0),
                       ($urandom_range(4) == 0) ? $urandom_range(63) : FRAME_W);
        end
    endtask

    task automatic test_reset_directed();
        // Hunting: pulses just outside each header window edge, and the field extremes.
        send_pulse(16'd22, 16'd5);
        send_pulse(16'd44, 16'd5);
        send_pulse(16'd30, 16'd2);
        send_pulse(16'd30, 16'd8);
        send_pulse(16'd0, 16'd0);
        send_pulse(16'hFFFF, 16'hFFFF);
        send_pulse(16'd23, 16'd3);
        // A header-shaped pulse inside a frame is judged as a data bit and fails.
        send_pulse(16'd30, 16'd5);
        send_pulse(16'd43, 16'd7);
        send_pulse(16'd2, 16'd1);
        send_pulse(16'd1, 16'd8);
        send_pulse(16'hFFFF, 16'd4);
        send_pulse(16'd4, 16'hFFFF);
        send_pulse(16'd4, 16'd4);
        send_pulse(16'd0, 16'd5);
        send_pulse(16'd23, 16'd3);
        send_pulse(16'd5, 16'd5);
        send_pulse(16'd23, 16'd3);
        send_pulse(16'd1, 16'd1);
        send_pulse(16'd23, 16'd3);
        send_pulse(16'd3, 16'd0);
    endtask

    task automatic test_spare_register_index();
        wait_until_idle();
        write_reg(REG_SPARE_LOW, 16'h0000);
        write_reg(REG_SPARE_HIGH, 16'hFFFF);
        cfg_valid <= 1'b0;
        send_pulse(16'd0, 16'd5);
        send_pulse(16'd100, 16'd5);
        send_pulse(16'd23, 16'd3);
        send_pulse(16'd3, 16'd2);
    endtask

    task automatic test_default_traffic();
        run_traffic(7);
    endtask

    task automatic test_config_sweep();
        cfg_t c;

        c.head_high_min  = 16'($urandom_range(2000, 10));
        c.head_high_max  = c.head_high_min + 16'($urandom_range(500));
        c.head_low_min   = 16'($urandom_range(2000, 10));
        c.head_low_max   = c.head_low_min + 16'($urandom_range(500));
        c.bit_period_min = 8'($urandom_range(60, 2));
        c.bit_period_max = c.bit_period_min + 8'($urandom_range(100));
        c.bit_part_min   = 16'($urandom_range(int'(c.bit_period_min) / 2));
        c.header_code    = 8'($urandom);
        load_settings(c);
        run_traffic(3);

        // Windows narrowed to a single value at the top and bottom of their range.
        c.head_high_min  = 16'hFFFF;
        c.head_high_max  = 16'hFFFF;
        c.head_low_min   = 16'hFFFF;
        c.head_low_max   = 16'hFFFF;
        c.bit_period_min = 8'd0;
        c.bit_period_max = 8'd0;
        c.bit_part_min   = 16'd0;
        c.header_code    = 8'hA5;
        load_settings(c);
        run_traffic(2);

        // Fully open: every pulse is a header or a data bit.
        c.head_high_min  = 16'd0;
        c.head_high_max  = 16'hFFFF;
        c.head_low_min   = 16'd0;
        c.head_low_max   = 16'hFFFF;
        c.bit_period_min = 8'd0;
        c.bit_period_max = 8'hFF;
        c.bit_part_min   = 16'd0;
        c.header_code    = 8'hFF;
        load_settings(c);
        repeat (130) send_noise();

        // Every minimum above its maximum: nothing may ever match.
        c.head_high_min  = 16'hFFFF;
        c.head_high_max  = 16'd0;
        c.head_low_min   = 16'hFFFF;
        c.head_low_max   = 16'd0;
        c.bit_period_min = 8'hFF;
        c.bit_period_max = 8'd0;
        c.bit_part_min   = 16'hFFFF;
        c.header_code    = 8'd0;
        load_settings(c);
        send_pulse(16'hFFFF, 16'hFFFF);
        send_pulse(16'd0, 16'd0);
        repeat (20) send_noise();
    endtask

    // The receiver stalls long enough for the pipe to fill and push back on the sender.
    task automatic test_backpressure();
        load_settings(CFG_RESET);
        fork
            hold_receiver(400);
        join_none
        run_traffic(2);
        wait_until_idle();
    endtask

    task automatic test_wide_pulses();
        cfg_t c;
        c.head_high_min  = 16'd1000;
        c.head_high_max  = 16'd60000;
        c.head_low_min   = 16'd400;
        c.head_low_max   = 16'd6500;
        c.bit_period_min = 8'd100;
        c.bit_period_max = 8'd180;
        c.bit_part_min   = 16'd1000;
        c.header_code    = 8'($urandom);
        load_settings(c);
        run_traffic(5);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 11;
        recv_idle_pct = 68;
        test_reset_directed();
        test_spare_register_index();
        test_default_traffic();

        send_idle_pct = 68;
        recv_idle_pct = 11;
        test_config_sweep();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_wide_pulses();

        wait_until_idle();
        $display("Covered %0d pulses and %0d register writes across default, swept, open,",
                 pulses_sent, reg_writes);
        $display("closed and wide settings; %0d results checked, %0d frames (%0d valid).",
                 results_checked, frames_done, frames_good);
        if (error_count == 0)
            $display("rf_pulse_width_frame_decoder regression: pass");
        else
            $display("rf_pulse_width_frame_decoder regression: fail");
        $finish;
    end

endmodule

FILE: rf_pulse_width_frame_decoder.f
+incdir+rtl
rtl/rfpwd_pkg.sv
rtl/rfpwd_classify.sv
rtl/rfpwd_frame.sv
rtl/rf_pulse_width_frame_decoder.sv
tb/rf_pulse_width_frame_decoder_tb.sv
